// ===== rtl/cpt_pkg.sv =====
// Shared widths and constants for the closest-point-on-triangle pipeline.
`default_nettype none
package cpt_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int WEIGHT_WIDTH = 16;
  localparam int FRAC_BITS = 15;
  localparam int AREA_WIDTH_DEF = 4 * COORD_WIDTH_DEF + 7;
  localparam logic [WEIGHT_WIDTH-1:0] ONE_Q15 = 16'h8000;
endpackage
`default_nettype wire

// ===== rtl/cpt_div.sv =====
// Pipelined signed ratio to unsigned Q1.15 weight, one quotient bit per stage.
`default_nettype none
module cpt_div
  import cpt_pkg::*;
#(
  parameter int NUM_WIDTH = AREA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [NUM_WIDTH-1:0] num,
  input  wire logic signed [NUM_WIDTH-1:0] den,
  output logic [WEIGHT_WIDTH-1:0]          quo
);
  localparam int RW = NUM_WIDTH + 1;

  logic signed [NUM_WIDTH-1:0] num_n;
  logic signed [NUM_WIDTH-1:0] den_n;
  logic                        zero_n;
  logic [NUM_WIDTH-1:0]        mag_num;
  logic [NUM_WIDTH-1:0]        mag_den;
  logic                        mag_zero;
  logic [RW-1:0]               rem [0:FRAC_BITS];
  logic [RW-1:0]               dvs [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]        q   [0:FRAC_BITS];
  logic                        sat [0:FRAC_BITS];
  logic                        zro [0:FRAC_BITS];

  always_comb begin
    if (den[NUM_WIDTH-1]) begin
      num_n = -num;
      den_n = -den;
    end else begin
      num_n = num;
      den_n = den;
    end
    zero_n = (den_n == '0) || num_n[NUM_WIDTH-1] || (num_n == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_num  <= num_n;
      mag_den  <= den_n;
      mag_zero <= zero_n;
      rem[0]   <= {1'b0, mag_num};
      dvs[0]   <= {1'b0, mag_den};
      q[0]     <= '0;
      sat[0]   <= (mag_num >= mag_den);
      zro[0]   <= mag_zero;
    end
  end

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem[i-1][RW-2:0], 1'b0};
    assign ge = (sh >= dvs[i-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? (sh - dvs[i-1]) : sh;
        dvs[i] <= dvs[i-1];
        q[i]   <= {q[i-1][FRAC_BITS-2:0], ge};
        sat[i] <= sat[i-1];
        zro[i] <= zro[i-1];
      end
    end
  end

  assign quo = zro[FRAC_BITS] ? '0 :
               sat[FRAC_BITS] ? ONE_Q15 : {1'b0, q[FRAC_BITS]};
endmodule
`default_nettype wire

// ===== rtl/closest_point_on_triangle.sv =====
// Closest point on a triangle to a query point, Voronoi region classification.
// Throughput: one transaction per cycle while the output is not stalled; the divide chain takes 17 of the stages.
// A stall on a valid output freezes every stage; bubbles travel with their valid bits.
// Reset clears the valid bits only; the data registers are not reset.
`default_nettype none
module closest_point_on_triangle
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] point_x,
  input  wire logic signed [COORD_WIDTH-1:0] point_y,
  input  wire logic signed [COORD_WIDTH-1:0] point_z,
  input  wire logic signed [COORD_WIDTH-1:0] vert_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] vert_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] vert_a_z,
  input  wire logic signed [COORD_WIDTH-1:0] vert_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] vert_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] vert_b_z,
  input  wire logic signed [COORD_WIDTH-1:0] vert_c_x,
  input  wire logic signed [COORD_WIDTH-1:0] vert_c_y,
  input  wire logic signed [COORD_WIDTH-1:0] vert_c_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      near_x,
  output logic signed [COORD_WIDTH-1:0]      near_y,
  output logic signed [COORD_WIDTH-1:0]      near_z,
  output logic [WEIGHT_WIDTH-1:0]            bary_u,
  output logic [WEIGHT_WIDTH-1:0]            bary_v,
  output logic [WEIGHT_WIDTH-1:0]            bary_w,
  output logic [2:0]                         region,
  output logic                               divide_fault
);
  localparam int W     = COORD_WIDTH;
  localparam int EW    = W + 1;
  localparam int PW2   = 2 * EW;
  localparam int DW    = 2 * W + 3;
  localparam int EDW   = DW + 1;
  localparam int H     = (DW + 1) / 2;
  localparam int HW    = DW - H;
  localparam int PW    = 2 * DW;
  localparam int AW    = PW + 1;
  localparam int TW    = EW + WEIGHT_WIDTH + 2;
  localparam int QW    = TW - FRAC_BITS;
  localparam int NW    = QW + 1;
  localparam int NST   = 27;
  localparam int GEO   = 26;
  localparam int GEO_D = GEO - 1;
  localparam int TAG   = 18;
  localparam int RND   = 1 << (FRAC_BITS - 1);
  localparam longint CMAX = (longint'(1) << (W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  localparam logic [2:0] RGN_VERT_A   = 3'd0;
  localparam logic [2:0] RGN_VERT_B   = 3'd1;
  localparam logic [2:0] RGN_EDGE_AB  = 3'd2;
  localparam logic [2:0] RGN_VERT_C   = 3'd3;
  localparam logic [2:0] RGN_EDGE_BC  = 3'd4;
  localparam logic [2:0] RGN_EDGE_CA  = 3'd5;
  localparam logic [2:0] RGN_INTERIOR = 3'd6;

  localparam int PA [0:5] = '{0, 1, 2, 3, 4, 5};
  localparam int PB [0:5] = '{3, 2, 5, 4, 1, 0};

  logic adv;
  logic vld [0:NST-1];

  logic signed [W-1:0]  pin [0:2];
  logic signed [W-1:0]  ain [0:2];
  logic signed [W-1:0]  bin [0:2];
  logic signed [W-1:0]  cin [0:2];

  logic signed [W-1:0]  ga  [0:GEO-1][0:2];
  logic signed [EW-1:0] gab [0:GEO_D-1][0:2];
  logic signed [EW-1:0] gac [0:GEO_D-1][0:2];
  logic signed [EW-1:0] ap1 [0:2];
  logic signed [EW-1:0] bp1 [0:2];
  logic signed [EW-1:0] cp1 [0:2];

  logic signed [PW2-1:0] pr2 [0:5][0:2];
  logic signed [DW-1:0]  d3s [0:5];
  logic signed [DW-1:0]  d4s [0:5];
  logic signed [DW-1:0]  d5s [0:5];
  logic signed [DW-1:0]  d6s [0:5];

  logic signed [2*HW-1:0] phh [0:5];
  logic signed [HW+H:0]   phl [0:5];
  logic signed [HW+H:0]   plh [0:5];
  logic [2*H-1:0]         pll [0:5];
  logic signed [PW-1:0]   pr5 [0:5];

  logic signed [AW-1:0]  va6;
  logic signed [AW-1:0]  vb6;
  logic signed [AW-1:0]  vc6;
  logic signed [EDW-1:0] ebc6;
  logic signed [EDW-1:0] ecb6;

  logic signed [AW-1:0] den_all;
  logic [2:0]           rg_next;
  logic                 flt_next;
  logic signed [AW-1:0] numv_next;
  logic signed [AW-1:0] denv_next;
  logic signed [AW-1:0] numw_next;
  logic signed [AW-1:0] denw_next;
  logic signed [AW-1:0] numv7;
  logic signed [AW-1:0] denv7;
  logic signed [AW-1:0] numw7;
  logic signed [AW-1:0] denw7;
  logic [2:0]           rg  [0:TAG-1];
  logic                 flt [0:TAG-1];

  logic [WEIGHT_WIDTH-1:0] qv;
  logic [WEIGHT_WIDTH-1:0] qw;
  logic [WEIGHT_WIDTH:0]   vw_sum;
  logic [WEIGHT_WIDTH-1:0] kv_next;
  logic [WEIGHT_WIDTH-1:0] kw_next;
  logic [WEIGHT_WIDTH-1:0] ku25;
  logic [WEIGHT_WIDTH-1:0] kv25;
  logic [WEIGHT_WIDTH-1:0] kw25;
  logic [2:0]              rg25;
  logic                    flt25;

  logic signed [TW-1:0]    pmb [0:2];
  logic signed [TW-1:0]    pmc [0:2];
  logic [WEIGHT_WIDTH-1:0] ku26;
  logic [WEIGHT_WIDTH-1:0] kv26;
  logic [WEIGHT_WIDTH-1:0] kw26;
  logic [2:0]              rg26;
  logic                    flt26;

  logic signed [TW-1:0] tsum [0:2];
  logic signed [TW-1:0] tsh  [0:2];
  logic signed [NW-1:0] nsum [0:2];
  logic signed [W-1:0]  nsat [0:2];

  assign in_stall  = out_valid && out_stall;
  assign adv       = !in_stall;
  assign out_valid = vld[NST-1];

  assign pin[0] = point_x;
  assign pin[1] = point_y;
  assign pin[2] = point_z;
  assign ain[0] = vert_a_x;
  assign ain[1] = vert_a_y;
  assign ain[2] = vert_a_z;
  assign bin[0] = vert_b_x;
  assign bin[1] = vert_b_y;
  assign bin[2] = vert_b_z;
  assign cin[0] = vert_c_x;
  assign cin[1] = vert_c_y;
  assign cin[2] = vert_c_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ap1[i]    <= EW'(pin[i]) - EW'(ain[i]);
        bp1[i]    <= EW'(pin[i]) - EW'(bin[i]);
        cp1[i]    <= EW'(pin[i]) - EW'(cin[i]);
        ga[0][i]  <= ain[i];
        gab[0][i] <= EW'(bin[i]) - EW'(ain[i]);
        gac[0][i] <= EW'(cin[i]) - EW'(ain[i]);
      end
      for (int k = 1; k < GEO; k++) begin
        for (int i = 0; i < 3; i++) ga[k][i] <= ga[k-1][i];
      end
      for (int k = 1; k < GEO_D; k++) begin
        for (int i = 0; i < 3; i++) begin
          gab[k][i] <= gab[k-1][i];
          gac[k][i] <= gac[k-1][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        pr2[0][i] <= ap1[i] * gab[0][i];
        pr2[1][i] <= ap1[i] * gac[0][i];
        pr2[2][i] <= bp1[i] * gab[0][i];
        pr2[3][i] <= bp1[i] * gac[0][i];
        pr2[4][i] <= cp1[i] * gab[0][i];
        pr2[5][i] <= cp1[i] * gac[0][i];
      end
      for (int j = 0; j < 6; j++) begin
        d3s[j] <= DW'(pr2[j][0]) + DW'(pr2[j][1]) + DW'(pr2[j][2]);
        d4s[j] <= d3s[j];
        d5s[j] <= d4s[j];
        d6s[j] <= d5s[j];
      end
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_area
    always_ff @(posedge clk) begin
      if (adv) begin
        phh[k] <= $signed(d3s[PA[k]][DW-1:H]) * $signed(d3s[PB[k]][DW-1:H]);
        phl[k] <= $signed(d3s[PA[k]][DW-1:H]) * $signed({1'b0, d3s[PB[k]][H-1:0]});
        plh[k] <= $signed({1'b0, d3s[PA[k]][H-1:0]}) * $signed(d3s[PB[k]][DW-1:H]);
        pll[k] <= d3s[PA[k]][H-1:0] * d3s[PB[k]][H-1:0];
        pr5[k] <= (PW'(phh[k]) <<< (2 * H)) + ((PW'(phl[k]) + PW'(plh[k])) <<< H)
                  + PW'(pll[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vc6  <= AW'(pr5[0]) - AW'(pr5[1]);
      va6  <= AW'(pr5[2]) - AW'(pr5[3]);
      vb6  <= AW'(pr5[4]) - AW'(pr5[5]);
      ebc6 <= EDW'(d5s[3]) - EDW'(d5s[2]);
      ecb6 <= EDW'(d5s[4]) - EDW'(d5s[5]);
    end
  end

  always_comb begin
    den_all   = va6 + vb6 + vc6;
    rg_next   = RGN_INTERIOR;
    flt_next  = 1'b0;
    numv_next = '0;
    denv_next = '0;
    numw_next = '0;
    denw_next = '0;
    if (d6s[0] <= 0 && d6s[1] <= 0) begin
      rg_next = RGN_VERT_A;
    end else if (d6s[2] >= 0 && ebc6 <= 0) begin
      rg_next = RGN_VERT_B;
    end else if (vc6 <= 0 && d6s[0] >= 0 && d6s[2] <= 0) begin
      rg_next   = RGN_EDGE_AB;
      numv_next = AW'(d6s[0]);
      denv_next = AW'(d6s[0]) - AW'(d6s[2]);
    end else if (ecb6 <= 0 && d6s[5] >= 0) begin
      rg_next = RGN_VERT_C;
    end else if (va6 <= 0 && ebc6 >= 0 && ecb6 >= 0) begin
      rg_next   = RGN_EDGE_BC;
      numw_next = AW'(ebc6);
      denw_next = AW'(ebc6) + AW'(ecb6);
    end else if (vb6 <= 0 && d6s[1] >= 0 && d6s[5] <= 0) begin
      rg_next   = RGN_EDGE_CA;
      numw_next = AW'(d6s[1]);
      denw_next = AW'(d6s[1]) - AW'(d6s[5]);
    end else begin
      flt_next  = (den_all == '0);
      numv_next = vb6;
      denv_next = den_all;
      numw_next = vc6;
      denw_next = den_all;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      numv7  <= numv_next;
      denv7  <= denv_next;
      numw7  <= numw_next;
      denw7  <= denw_next;
      rg[0]  <= rg_next;
      flt[0] <= flt_next;
      for (int k = 1; k < TAG; k++) begin
        rg[k]  <= rg[k-1];
        flt[k] <= flt[k-1];
      end
    end
  end

  cpt_div #(.NUM_WIDTH(AW)) u_div_v (
    .clk (clk),
    .en  (adv),
    .num (numv7),
    .den (denv7),
    .quo (qv)
  );

  cpt_div #(.NUM_WIDTH(AW)) u_div_w (
    .clk (clk),
    .en  (adv),
    .num (numw7),
    .den (denw7),
    .quo (qw)
  );

  always_comb begin
    vw_sum  = {1'b0, qv} + {1'b0, qw};
    kv_next = '0;
    kw_next = '0;
    unique case (rg[TAG-1])
      RGN_VERT_A: begin
        kv_next = '0;
      end
      RGN_VERT_B: begin
        kv_next = ONE_Q15;
      end
      RGN_EDGE_AB: begin
        kv_next = qv;
      end
      RGN_VERT_C: begin
        kw_next = ONE_Q15;
      end
      RGN_EDGE_BC: begin
        kw_next = qw;
        kv_next = ONE_Q15 - qw;
      end
      RGN_EDGE_CA: begin
        kw_next = qw;
      end
      RGN_INTERIOR: begin
        if (!flt[TAG-1]) begin
          kv_next = qv;
          kw_next = (vw_sum > {1'b0, ONE_Q15}) ? (ONE_Q15 - qv) : qw;
        end
      end
      default: begin
        kv_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kv25  <= kv_next;
      kw25  <= kw_next;
      ku25  <= ONE_Q15 - kv_next - kw_next;
      rg25  <= rg[TAG-1];
      flt25 <= flt[TAG-1];
      for (int i = 0; i < 3; i++) begin
        pmb[i] <= $signed({1'b0, kv25}) * gab[GEO_D-1][i];
        pmc[i] <= $signed({1'b0, kw25}) * gac[GEO_D-1][i];
      end
      ku26  <= ku25;
      kv26  <= kv25;
      kw26  <= kw25;
      rg26  <= rg25;
      flt26 <= flt25;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = pmb[i] + pmc[i] + TW'(RND);
      tsh[i]  = tsum[i] >>> FRAC_BITS;
      nsum[i] = NW'(ga[GEO-1][i]) + NW'(tsh[i]);
      if (nsum[i] > NW'(CMAX)) begin
        nsat[i] = W'(CMAX);
      end else if (nsum[i] < NW'(CMIN)) begin
        nsat[i] = W'(CMIN);
      end else begin
        nsat[i] = W'(nsum[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      near_x       <= nsat[0];
      near_y       <= nsat[1];
      near_z       <= nsat[2];
      bary_u       <= ku26;
      bary_v       <= kv26;
      bary_w       <= kw26;
      region       <= rg26;
      divide_fault <= flt26;
    end
  end

`ifndef SYNTHESIS
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (17'(bary_u) + 17'(bary_v) + 17'(bary_w)) == 17'(ONE_Q15))
    else $error("barycentric weights do not sum to one");

  a_fault_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_fault |-> region == RGN_INTERIOR && bary_u == ONE_Q15)
    else $error("divide fault outside degenerate interior result");

  a_vertex_a: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == RGN_VERT_A |-> bary_u == ONE_Q15 && !divide_fault)
    else $error("vertex A region with wrong weights");
`endif
endmodule
`default_nettype wire
